// File: rtl/sca_pkg.sv
// Shared types and constants of the size-class slab allocator.
`timescale 1ns / 1ps

package sca_pkg;

  // Fixed field widths of the request and result
  localparam int SIZE_W     = 32;
  localparam int ADDR_W     = 18;
  localparam int LINK_AW    = 15;
  localparam int LINK_DEPTH = 32768;
  localparam int HEAD_W     = 16;

  // Packed stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;

  // Request kinds carried on tuser
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NULL      = 2'd1,
    STAT_TOO_LARGE = 2'd2,
    STAT_OOM       = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CLS_RD,
    S_CLS_EVAL,
    S_LINK_WB,
    S_RESP
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic decode;
    logic cls_rd;
    logic cls_eval;
    logic link_wb;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic bad;
    logic is_free;
    logic head_valid;
    logic out_room;
  } dp_sts_t;

endpackage

// File: rtl/size_class_slab_allocator.sv
// Size-class slab allocator: top level joining controller and datapath.
//
// Requests enter on the s_axis channel: tuser is the kind (0 allocate,
// 1 free), tdata carries the byte size and, for a free, the pool offset.
// Results leave on the m_axis channel: slot offset and a 2-bit status
// (ok, zero size, too large, class out of memory).
// One request is handled at a time. After acceptance the request passes
// through decode and the class memory read; a zero or oversize request then
// goes to the response state, a free, a bump allocation or an out-of-memory
// reply first passes the class evaluation, and an allocation popped from a
// free list also the link memory read and write-back. The result is loaded
// into the output register in the response state, and the next request can
// be taken the cycle after. Both memories have registered read data.
// The output register frees the request side: a new request is accepted
// while a result still waits; if m_axis_tready stays low the next result
// waits in the response state until the register empties.
// Reset empties every free list and zeroes every bump offset at once; the
// link memory is not cleared.
`timescale 1ns / 1ps

module size_class_slab_allocator
  import sca_pkg::*;
#(
  parameter int NUM_CLASSES  = 64,
  parameter int SLOT_GRANULE = 8,
  parameter int REGION_BYTES = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // req_size[31:0], free_addr[49:32], pad
  input  logic                   s_axis_tuser,   // req_type
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // slot_addr[17:0], status[19:18], pad
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  sca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sca_datapath #(
    .NUM_CLASSES  (NUM_CLASSES),
    .SLOT_GRANULE (SLOT_GRANULE),
    .REGION_BYTES (REGION_BYTES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .out_tready_i (m_axis_tready),
    .out_tvalid_o (m_axis_tvalid),
    .out_tdata_o  (m_axis_tdata)
  );

endmodule

// File: rtl/sca_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module sca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/sca_datapath.sv
// Datapath: request registers, class decode, class and link memories, result register.
`timescale 1ns / 1ps

module sca_datapath
  import sca_pkg::*;
#(
  parameter int NUM_CLASSES  = 64,
  parameter int SLOT_GRANULE = 8,
  parameter int REGION_BYTES = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctrl_cmd_t              cmd_i,
  output dp_sts_t                sts_o,
  input  logic [IN_TDATA_W-1:0]  in_tdata_i,
  input  logic                   in_tuser_i,
  input  logic                   out_tready_i,
  output logic                   out_tvalid_o,
  output logic [OUT_TDATA_W-1:0] out_tdata_o
);

  localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int GB     = $clog2(SLOT_GRANULE);
  localparam int BUMP_W = $clog2(REGION_BYTES + 1);
  localparam int CRAM_W = HEAD_W + BUMP_W;
  // size - 1 stays below NUM_CLASSES * SLOT_GRANULE
  localparam int SZW    = $clog2(NUM_CLASSES * SLOT_GRANULE);
  // Reciprocal constants for exact division by the granule
  localparam int SIZE_S = SZW + GB;
  localparam int SIZE_M = ((1 << SIZE_S) + SLOT_GRANULE - 1) / SLOT_GRANULE;
  localparam int SIZE_P = SZW + SIZE_S;
  localparam int ADDR_S = ADDR_W + GB;
  localparam int ADDR_M = ((1 << ADDR_S) + SLOT_GRANULE - 1) / SLOT_GRANULE;
  localparam int ADDR_P = ADDR_W + ADDR_S;
  localparam logic [SIZE_W-1:0] MaxSize   = SIZE_W'(NUM_CLASSES * SLOT_GRANULE);
  localparam logic [ADDR_W-1:0] GranC     = ADDR_W'(SLOT_GRANULE);
  localparam logic [ADDR_W-1:0] RegionC   = ADDR_W'(REGION_BYTES);
  localparam logic [ADDR_W:0]   RegionLim = (ADDR_W + 1)'(REGION_BYTES);

  // Request registers
  logic              type_q;
  logic [SIZE_W-1:0] size_q;
  logic [ADDR_W-1:0] faddr_q;

  // Decoded request
  logic               bad_q, bad_d;
  logic [CLS_W-1:0]   cls_q, cls_d;
  logic [LINK_AW-1:0] gidx_q, gidx_d;
  logic [ADDR_W-1:0]  slot_q, slot_d;
  logic [ADDR_W-1:0]  base_q, base_d;
  logic [BUMP_W-1:0]  bump_keep_q, bump_keep_d;

  // Result and output registers
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  status_e           res_stat_q, res_stat_d;
  logic              out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] out_addr_q;
  status_e           out_stat_q;

  // Class touched bits stand in for the reset of the class memory
  logic [NUM_CLASSES-1:0] touched_q, touched_d;

  // Memory ports
  logic               cls_we;
  logic [CRAM_W-1:0]  cls_wdata;
  logic [CRAM_W-1:0]  cls_rdata;
  logic               link_we;
  logic               link_re;
  logic [HEAD_W-1:0]  link_rdata;

  // Decode arithmetic
  logic [SIZE_W-1:0]  size_m1;
  logic [SIZE_P-1:0]  size_prod;
  logic [ADDR_P-1:0]  addr_prod;
  logic               size_zero;
  logic               size_big;
  logic [CLS_W:0]     cls_p1;

  // Evaluation arithmetic
  logic [HEAD_W-1:0]  head_cur;
  logic [BUMP_W-1:0]  bump_cur;
  logic               head_vld;
  logic [LINK_AW-1:0] head_idx;
  logic [ADDR_W:0]    bump_sum;
  logic               bump_fits;
  logic [ADDR_W-1:0]  pop_addr;
  logic [ADDR_W-1:0]  bump_addr;

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      type_q  <= in_tuser_i;
      size_q  <= in_tdata_i[SIZE_W-1:0];
      faddr_q <= in_tdata_i[SIZE_W +: ADDR_W];
    end
  end

  // Classify the size and divide by the granule
  always_comb begin
    size_m1   = size_q - SIZE_W'(1);
    size_zero = (size_q == '0);
    size_big  = (size_q > MaxSize);
    size_prod = SIZE_P'(size_m1[SZW-1:0]) * SIZE_P'(SIZE_M);
    addr_prod = ADDR_P'(faddr_q) * ADDR_P'(ADDR_M);
    cls_p1    = {1'b0, cls_q} + (CLS_W + 1)'(1);
  end

  // Current class entry, empty until first written
  always_comb begin
    head_cur  = touched_q[cls_q] ? cls_rdata[HEAD_W-1:0] : '0;
    bump_cur  = touched_q[cls_q] ? cls_rdata[HEAD_W +: BUMP_W] : '0;
    head_vld  = head_cur[HEAD_W-1];
    head_idx  = head_cur[LINK_AW-1:0];
    bump_sum  = {1'b0, ADDR_W'(bump_cur)} + {1'b0, slot_q};
    bump_fits = (bump_sum <= RegionLim);
    pop_addr  = ADDR_W'(head_idx) * GranC;
    bump_addr = base_q + ADDR_W'(bump_cur);
  end

  // Next values of the decode, result and memory controls
  always_comb begin
    bad_d       = bad_q;
    cls_d       = cls_q;
    gidx_d      = gidx_q;
    slot_d      = slot_q;
    base_d      = base_q;
    bump_keep_d = bump_keep_q;
    res_addr_d  = res_addr_q;
    res_stat_d  = res_stat_q;
    cls_we      = 1'b0;
    cls_wdata   = '0;
    link_we     = 1'b0;
    link_re     = 1'b0;

    if (cmd_i.decode) begin
      bad_d      = size_zero | size_big;
      cls_d      = size_prod[SIZE_S +: CLS_W];
      gidx_d     = addr_prod[ADDR_S +: LINK_AW];
      res_addr_d = '0;
      res_stat_d = size_zero ? STAT_NULL : (size_big ? STAT_TOO_LARGE : STAT_OK);
    end

    if (cmd_i.cls_rd) begin
      slot_d = ADDR_W'(cls_p1) * GranC;
      base_d = ADDR_W'(cls_q) * RegionC;
    end

    if (cmd_i.cls_eval) begin
      if (type_q == REQ_FREE) begin
        // Push: the slot becomes the head, the old head goes to its link
        cls_we     = 1'b1;
        cls_wdata  = {bump_cur, 1'b1, gidx_q};
        link_we    = 1'b1;
        res_addr_d = '0;
        res_stat_d = STAT_OK;
      end else if (head_vld) begin
        // Pop: fetch the next link, head is rewritten afterwards
        link_re     = 1'b1;
        bump_keep_d = bump_cur;
        res_addr_d  = pop_addr;
        res_stat_d  = STAT_OK;
      end else if (bump_fits) begin
        cls_we     = 1'b1;
        cls_wdata  = {BUMP_W'(bump_sum), head_cur};
        res_addr_d = bump_addr;
        res_stat_d = STAT_OK;
      end else begin
        res_addr_d = '0;
        res_stat_d = STAT_OOM;
      end
    end

    if (cmd_i.link_wb) begin
      cls_we    = 1'b1;
      cls_wdata = {bump_keep_q, link_rdata};
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cls_q       <= cls_d;
    gidx_q      <= gidx_d;
    slot_q      <= slot_d;
    base_q      <= base_d;
    bump_keep_q <= bump_keep_d;
    res_addr_q  <= res_addr_d;
    res_stat_q  <= res_stat_d;
    bad_q       <= bad_d;
    if (cmd_i.load_out) begin
      out_addr_q <= res_addr_q;
      out_stat_q <= res_stat_q;
    end
  end

  // Mark classes as written and track the output register
  always_comb begin
    touched_d = touched_q;
    if (cls_we) begin
      touched_d[cls_q] = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touched_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      touched_q   <= touched_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Per-class head and bump offset
  sca_ram #(
    .WIDTH (CRAM_W),
    .DEPTH (NUM_CLASSES)
  ) u_cls_ram (
    .clk_i   (clk_i),
    .we_i    (cls_we),
    .waddr_i (cls_q),
    .wdata_i (cls_wdata),
    .re_i    (cmd_i.cls_rd),
    .raddr_i (cls_q),
    .rdata_o (cls_rdata)
  );

  // Free-list links indexed by granule address
  sca_ram #(
    .WIDTH (HEAD_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (gidx_q),
    .wdata_i (head_cur),
    .re_i    (link_re),
    .raddr_i (head_idx),
    .rdata_o (link_rdata)
  );

  assign sts_o.bad        = bad_q;
  assign sts_o.is_free    = (type_q == REQ_FREE);
  assign sts_o.head_valid = head_vld;
  assign sts_o.out_room   = !out_valid_q || out_tready_i;

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = {(OUT_TDATA_W - ADDR_W - 2)'(0), out_stat_q, out_addr_q};

  // Never overwrite a result still waiting at the output
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_tready_i))
    else $error("result loaded over a pending result");

  // A bump never moves past the end of the class region
  a_bump_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cls_we && cmd_i.cls_eval && type_q == REQ_ALLOC) |->
      (ADDR_W'(cls_wdata[HEAD_W +: BUMP_W]) <= RegionC || REGION_BYTES >= (1 << ADDR_W)))
    else $error("bump offset beyond region");

endmodule

// File: rtl/sca_ctrl.sv
// Controller: sequences each request through decode, class lookup, link access and response.
`timescale 1ns / 1ps

module sca_ctrl
  import sca_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_DECODE;
      S_DECODE:   state_d = S_CLS_RD;
      S_CLS_RD:   state_d = sts_i.bad ? S_RESP : S_CLS_EVAL;
      S_CLS_EVAL: state_d = (!sts_i.is_free && sts_i.head_valid) ? S_LINK_WB : S_RESP;
      S_LINK_WB:  state_d = S_RESP;
      S_RESP:     if (sts_i.out_room) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_DECODE:   cmd_o.decode   = 1'b1;
      S_CLS_RD:   cmd_o.cls_rd   = !sts_i.bad;
      S_CLS_EVAL: cmd_o.cls_eval = 1'b1;
      S_LINK_WB:  cmd_o.link_wb  = 1'b1;
      S_RESP:     cmd_o.load_out = sts_i.out_room;
      default:    cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The link write-back only follows a class evaluation
  a_link_after_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINK_WB) |-> ($past(state_q) == S_CLS_EVAL))
    else $error("link write-back without class evaluation");

  // An accepted request always starts decoding next
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q == S_DECODE))
    else $error("accepted request not decoded");

  // A pop never reaches the write-back for a free request
  a_free_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLS_EVAL && sts_i.is_free) |=> (state_q == S_RESP))
    else $error("free request entered the pop path");

endmodule
